// ----- hw/rtl/tlb_pkg.sv -----
// Package: shared types, constants and the SPI bit expansion for the tilt LED bar encoder.
`default_nettype none
package tlb_pkg;

    localparam int LED_COUNT_DEF = 8;
    localparam int LED_W         = 3;
    localparam int THR_W         = 15;
    localparam int AXIS_W        = 16;

    localparam logic [THR_W-1:0] THR_RESET = 15'd3277;

    localparam logic [7:0] SPI_ONE  = 8'h7c;
    localparam logic [7:0] SPI_ZERO = 8'h40;

    localparam logic [1:0] CH_GREEN = 2'd0;
    localparam logic [1:0] CH_RED   = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [2:0] {
        DIR_NONE   = 3'd0,
        DIR_X_LOW  = 3'd1,
        DIR_X_HIGH = 3'd2,
        DIR_Y_HIGH = 3'd3,
        DIR_Y_LOW  = 3'd4
    } t_dir;

    typedef struct packed {
        t_dir             dir;
        logic [LED_W-1:0] run;
    } t_frame_desc;

    function automatic logic [63:0] expand_byte(input logic [7:0] color);
        logic [63:0] pat;
        pat = '0;
        for (int b = 0; b < 8; b++) begin
            pat[8*b +: 8] = color[b] ? SPI_ONE : SPI_ZERO;
        end
        return pat;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tlb_classify.sv -----
// Tilt classification, run counter and frame descriptor register.
`default_nettype none
module tlb_classify
    import tlb_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic [THR_W-1:0]  i_cfg_tilt_threshold,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [AXIS_W-1:0] i_accel_x,
    input  wire logic [AXIS_W-1:0] i_accel_y,
    output logic                   o_desc_valid,
    input  wire logic              i_desc_take,
    output t_frame_desc            o_desc
);

    localparam logic [LED_W-1:0] RunMax = LED_W'(LED_COUNT - 1);

    logic [THR_W-1:0] r_threshold;
    t_dir             r_last_dir;
    logic [LED_W-1:0] r_run;
    logic             r_desc_valid;
    t_frame_desc      r_desc;

    logic signed [AXIS_W:0] x_ext;
    logic signed [AXIS_W:0] y_ext;
    logic signed [AXIS_W:0] thr_pos;
    logic signed [AXIS_W:0] thr_neg;
    t_dir                   dir;
    logic [LED_W-1:0]       n_run;
    logic                   accept;

    assign x_ext   = {i_accel_x[AXIS_W-1], i_accel_x};
    assign y_ext   = {i_accel_y[AXIS_W-1], i_accel_y};
    assign thr_pos = {2'b00, r_threshold};
    assign thr_neg = -thr_pos;

    always_comb begin
        if (x_ext <= thr_neg) begin
            dir = DIR_X_LOW;
        end else if (x_ext >= thr_pos) begin
            dir = DIR_X_HIGH;
        end else if (y_ext >= thr_pos) begin
            dir = DIR_Y_HIGH;
        end else if (y_ext <= thr_neg) begin
            dir = DIR_Y_LOW;
        end else begin
            dir = DIR_NONE;
        end
    end

    always_comb begin
        if (dir == r_last_dir) begin
            n_run = (r_run < RunMax) ? r_run + LED_W'(1) : RunMax;
        end else begin
            n_run = '0;
        end
    end

    assign o_in_ready   = !r_desc_valid || i_desc_take;
    assign accept       = i_in_valid && o_in_ready;
    assign o_desc_valid = r_desc_valid;
    assign o_desc       = r_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THR_RESET;
            r_last_dir   <= DIR_NONE;
            r_run        <= '0;
            r_desc_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_threshold <= i_cfg_tilt_threshold;
            end
            if (accept) begin
                r_last_dir   <= dir;
                r_run        <= n_run;
                r_desc_valid <= 1'b1;
            end else if (i_desc_take) begin
                r_desc_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_desc.dir <= dir;
            r_desc.run <= n_run;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/tlb_emitter.sv -----
// Frame emitter: walks LEDs and channels of one frame into the output register.
`default_nettype none
module tlb_emitter
    import tlb_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_desc_valid,
    output logic               o_desc_take,
    input  wire t_frame_desc   i_desc,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [LED_W-1:0]   o_led_index,
    output logic [1:0]         o_channel,
    output logic [63:0]        o_spi_pattern,
    output logic               o_last
);

    localparam logic [LED_W-1:0] LedTop = LED_W'(LED_COUNT - 1);

    logic             r_busy;
    t_frame_desc      r_frame;
    logic [LED_W-1:0] r_led;
    logic [1:0]       r_ch;
    logic             r_out_valid;
    logic [LED_W-1:0] r_out_led;
    logic [1:0]       r_out_ch;
    logic [63:0]      r_out_pat;
    logic             r_out_last;

    logic             out_adv;
    logic             is_last;
    logic             lit;
    logic             lvl;

    assign out_adv     = !r_out_valid || i_out_ready;
    assign is_last     = (r_led == LedTop) && (r_ch == CH_BLUE);
    assign o_desc_take = i_desc_valid && (!r_busy || (out_adv && is_last));

    always_comb begin
        if (r_frame.dir == DIR_Y_HIGH) begin
            lit = r_led >= (LedTop - r_frame.run);
        end else begin
            lit = r_led <= r_frame.run;
        end
        case (r_ch)
            CH_GREEN: lvl = (r_frame.dir == DIR_X_LOW) || (r_frame.dir == DIR_Y_HIGH);
            CH_RED:   lvl = (r_frame.dir == DIR_Y_HIGH) || (r_frame.dir == DIR_Y_LOW);
            default:  lvl = (r_frame.dir == DIR_X_HIGH) || (r_frame.dir == DIR_Y_HIGH);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_led       <= '0;
            r_ch        <= CH_GREEN;
        end else begin
            if (out_adv) begin
                r_out_valid <= r_busy;
            end
            if (o_desc_take) begin
                r_busy <= 1'b1;
                r_led  <= '0;
                r_ch   <= CH_GREEN;
            end else if (out_adv && r_busy) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end else if (r_ch == CH_BLUE) begin
                    r_ch  <= CH_GREEN;
                    r_led <= r_led + LED_W'(1);
                end else begin
                    r_ch <= r_ch + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_desc_take) begin
            r_frame <= i_desc;
        end
        if (out_adv && r_busy) begin
            r_out_led  <= r_led;
            r_out_ch   <= r_ch;
            r_out_pat  <= expand_byte({7'd0, lit && lvl});
            r_out_last <= is_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_led_index   = r_out_led;
    assign o_channel     = r_out_ch;
    assign o_spi_pattern = r_out_pat;
    assign o_last        = r_out_last;

endmodule
`default_nettype wire

// ----- hw/rtl/tilt_led_bar_ws2812_encoder_core.sv -----
// Top level of the tilt LED bar WS2812 frame encoder.
// A sample passes the descriptor register, the emitter frame register once taken, then the output register.
// The emitter walk gives one channel item per cycle while the output is ready, LED_COUNT*3 items per sample.
// One sample waits in the descriptor register while the emitter works on the previous frame.
// Reset (synchronous, active low): threshold 3277, direction and run count zero, pipeline empty.
`default_nettype none
module tilt_led_bar_ws2812_encoder_core
    import tlb_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [THR_W-1:0]  i_cfg_tilt_threshold,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [AXIS_W-1:0] i_accel_x,
    input  wire logic [AXIS_W-1:0] i_accel_y,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [LED_W-1:0]       o_led_index,
    output logic [1:0]             o_channel,
    output logic [63:0]            o_spi_pattern,
    output logic                   o_last
);

    logic        desc_valid;
    logic        desc_take;
    t_frame_desc desc;

    assign o_cfg_ready = 1'b1;

    tlb_classify #(
        .LED_COUNT(LED_COUNT)
    ) u_classify (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_tilt_threshold (i_cfg_tilt_threshold),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_accel_x            (i_accel_x),
        .i_accel_y            (i_accel_y),
        .o_desc_valid         (desc_valid),
        .i_desc_take          (desc_take),
        .o_desc               (desc)
    );

    tlb_emitter #(
        .LED_COUNT(LED_COUNT)
    ) u_emitter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_desc_valid  (desc_valid),
        .o_desc_take   (desc_take),
        .i_desc        (desc),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_led_index   (o_led_index),
        .o_channel     (o_channel),
        .o_spi_pattern (o_spi_pattern),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

// ----- test/tilt_led_bar_ws2812_encoder_core_tb.sv -----
// Self-checking testbench: tilt samples and threshold writes in, every LED channel item checked.
module tilt_led_bar_ws2812_encoder_core_tb;
    import tlb_pkg::*;

    localparam int LEDS        = LED_COUNT_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
    } t_sample;

    typedef struct {
        logic [LED_W-1:0] led;
        logic [1:0]       ch;
        logic [63:0]      pattern;
        logic             last;
    } t_channel_item;

    logic              i_clk                = 1'b0;
    logic              i_rst_n              = 1'b0;
    logic              i_cfg_valid          = 1'b0;
    logic              o_cfg_ready;
    logic [THR_W-1:0]  i_cfg_tilt_threshold = '0;
    logic              i_in_valid           = 1'b0;
    logic              o_in_ready;
    logic [AXIS_W-1:0] i_accel_x            = '0;
    logic [AXIS_W-1:0] i_accel_y            = '0;
    logic              o_out_valid;
    logic              i_out_ready          = 1'b0;
    logic [LED_W-1:0]  o_led_index;
    logic [1:0]        o_channel;
    logic [63:0]       o_spi_pattern;
    logic              o_last;

    t_sample       pending_samples[$];
    t_channel_item frame_expect[$];
    t_sample       next_sample;
    t_channel_item want;

    logic [THR_W-1:0] thr_mirror = THR_RESET;
    t_dir             prev_dir   = DIR_NONE;
    logic [2:0]       run_len    = '0;

    int          src_idle_pct  = 0;
    int          snk_stall_pct = 0;
    int          errors        = 0;
    int unsigned cycles        = 0;

    tilt_led_bar_ws2812_encoder_core #(
        .LED_COUNT(LEDS)
    ) u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_tilt_threshold (i_cfg_tilt_threshold),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_accel_x            (i_accel_x),
        .i_accel_y            (i_accel_y),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_led_index          (o_led_index),
        .o_channel            (o_channel),
        .o_spi_pattern        (o_spi_pattern),
        .o_last               (o_last)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_dir classify_tilt(input logic signed [AXIS_W-1:0] x,
                                           input logic signed [AXIS_W-1:0] y,
                                           input logic [THR_W-1:0] thr);
        int sx;
        int sy;
        int t;
        sx = x;
        sy = y;
        t  = thr;
        if (sx <= -t) return DIR_X_LOW;
        if (sx >= t) return DIR_X_HIGH;
        if (sy >= t) return DIR_Y_HIGH;
        if (sy <= -t) return DIR_Y_LOW;
        return DIR_NONE;
    endfunction

    function automatic logic [63:0] spi_expand(input logic [7:0] color);
        logic [63:0] pat;
        pat = '0;
        for (int i = 7; i >= 0; i--) begin
            pat = {pat[55:0], color[i] ? SPI_ONE : SPI_ZERO};
        end
        return pat;
    endfunction

    task automatic encode_frame(input logic signed [AXIS_W-1:0] x,
                                input logic signed [AXIS_W-1:0] y);
        t_dir          dir;
        logic [2:0]    lvl;
        logic          lit;
        t_channel_item item;
        dir = classify_tilt(x, y, thr_mirror);
        if (dir == prev_dir) begin
            if (run_len < LEDS - 1) run_len = run_len + 1'b1;
        end else begin
            run_len = '0;
        end
        prev_dir = dir;
        lvl = '0;
        case (dir)
            DIR_X_LOW:  lvl[CH_GREEN] = 1'b1;
            DIR_X_HIGH: lvl[CH_BLUE] = 1'b1;
            DIR_Y_HIGH: lvl = 3'b111;
            DIR_Y_LOW:  lvl[CH_RED] = 1'b1;
            default:    lvl = '0;
        endcase
        for (int led = 0; led < LEDS; led++) begin
            if (dir == DIR_Y_HIGH) lit = (led >= LEDS - 1 - int'(run_len));
            else lit = (led <= int'(run_len));
            for (int ch = CH_GREEN; ch <= CH_BLUE; ch++) begin
                item.led     = led[LED_W-1:0];
                item.ch      = ch[1:0];
                item.pattern = spi_expand({7'd0, lit & lvl[ch]});
                item.last    = (led == LEDS - 1) && (ch == CH_BLUE);
                frame_expect.push_back(item);
            end
        end
    endtask

    function automatic int rand_in(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int rand_inner(input int thr);
        if (thr == 0) return 0;
        return rand_in(-(thr - 1), thr - 1);
    endfunction

    function automatic t_sample shaped_sample(input t_dir dir, input int thr);
        t_sample s;
        s.x = AXIS_W'($urandom);
        s.y = AXIS_W'($urandom);
        case (dir)
            DIR_X_LOW:  s.x = AXIS_W'(rand_in(-32768, -thr));
            DIR_X_HIGH: s.x = AXIS_W'(rand_in(thr, 32767));
            DIR_Y_HIGH: begin
                s.x = AXIS_W'(rand_inner(thr));
                s.y = AXIS_W'(rand_in(thr, 32767));
            end
            DIR_Y_LOW: begin
                s.x = AXIS_W'(rand_inner(thr));
                s.y = AXIS_W'(rand_in(-32768, -thr));
            end
            default: begin
                s.x = AXIS_W'(rand_inner(thr));
                s.y = AXIS_W'(rand_inner(thr));
            end
        endcase
        return s;
    endfunction

    task automatic add_sample(input int x, input int y);
        t_sample s;
        s.x = AXIS_W'(x);
        s.y = AXIS_W'(y);
        pending_samples.push_back(s);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid          <= 1'b1;
        i_cfg_tilt_threshold <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        thr_mirror = value;
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || i_in_valid || frame_expect.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Mostly runs of one direction with random content, the rest raw noise.
    task automatic queue_random(input int count);
        int   added;
        int   run;
        t_dir dir;
        added = 0;
        while (added < count) begin
            if ($urandom_range(99) < 15) begin
                add_sample(int'($urandom_range(65535)), int'($urandom_range(65535)));
                added++;
            end else begin
                dir = t_dir'($urandom_range(4));
                run = $urandom_range(1, 10);
                for (int i = 0; i < run; i++)
                    pending_samples.push_back(shaped_sample(dir, int'(thr_mirror)));
                added += run;
            end
        end
    endtask

    task automatic run_phase(input logic [THR_W-1:0] thr, input int src_pct,
                             input int snk_pct, input int count);
        write_threshold(thr);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        queue_random(count);
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) encode_frame(i_accel_x, i_accel_y);
            if (!i_in_valid || o_in_ready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    next_sample = pending_samples.pop_front();
                    i_in_valid <= 1'b1;
                    i_accel_x  <= next_sample.x;
                    i_accel_y  <= next_sample.y;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (frame_expect.size() == 0) begin
                    $display("%0t: unexpected item led %0d ch %0d pattern %h last %b",
                             $time, o_led_index, o_channel, o_spi_pattern, o_last);
                    errors++;
                end else begin
                    want = frame_expect.pop_front();
                    if (o_led_index !== want.led) begin
                        $display("%0t: led_index expected %0d actual %0d",
                                 $time, want.led, o_led_index);
                        errors++;
                    end
                    if (o_channel !== want.ch) begin
                        $display("%0t: channel expected %0d actual %0d",
                                 $time, want.ch, o_channel);
                        errors++;
                    end
                    if (o_spi_pattern !== want.pattern) begin
                        $display("%0t: spi_pattern expected %h actual %h",
                                 $time, want.pattern, o_spi_pattern);
                        errors++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last expected %b actual %b",
                                 $time, want.last, o_last);
                        errors++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tilt_led_bar_ws2812_encoder_core verification failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_sample(0, 0);
        add_sample(-32768, 0);
        add_sample(-3277, 32767);
        add_sample(-3276, 0);
        add_sample(32767, -32768);
        add_sample(3277, 0);
        add_sample(3276, 3277);
        for (int i = 0; i < 8; i++) add_sample(-3276 + i * 900, 3277 + i * 3500);
        add_sample(0, -3277);
        add_sample(-3276, -32768);
        add_sample(0, -3276);
        wait_drained();

        write_threshold('0);
        add_sample(0, 0);
        add_sample(1, -32768);
        wait_drained();

        write_threshold(THR_W'(32767));
        add_sample(-32768, 0);
        add_sample(32766, -32767);
        add_sample(32767, 0);
        add_sample(0, 32767);
        add_sample(-32766, -32766);
        wait_drained();

        run_phase(THR_RESET, 0, 0, 37);
        run_phase(THR_W'(1), 61, 0, 36);
        run_phase(THR_W'($urandom_range(100, 8000)), 0, 61, 36);
        run_phase(THR_W'($urandom_range(32767)), 22, 22, 36);

        if (errors == 0 && frame_expect.size() == 0)
            $display("tilt_led_bar_ws2812_encoder_core verification clean");
        else
            $display("tilt_led_bar_ws2812_encoder_core verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/tlb_pkg.sv
hw/rtl/tlb_classify.sv
hw/rtl/tlb_emitter.sv
hw/rtl/tilt_led_bar_ws2812_encoder_core.sv
test/tilt_led_bar_ws2812_encoder_core_tb.sv
